### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

### src/stdp_pkg.sv
package stdp_pkg;

    localparam int NUM_PRE_DEF     = 64;
    localparam int NUM_POST_DEF    = 64;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int CMD_W      = 2;
    localparam int IDX_W      = 6;
    localparam int DATA_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 16;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int PROD_SHIFT = 24;
    localparam int DEC_SHIFT  = 16;

    localparam logic [CMD_W-1:0] CMD_POST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_LTP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_LTD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LTP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LTD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_THR   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_EN   = 3'd7;

    localparam logic [DATA_W-1:0]        RST_DECAY_LTP  = 16'd62339;
    localparam logic [DATA_W-1:0]        RST_DECAY_LTD  = 16'd62339;
    localparam logic [DATA_W-1:0]        RST_GAIN_LTP   = 16'd4096;
    localparam logic [DATA_W-1:0]        RST_GAIN_LTD   = 16'd4506;
    localparam logic signed [DATA_W-1:0] RST_WEIGHT_MIN = 16'sh0000;
    localparam logic signed [DATA_W-1:0] RST_WEIGHT_MAX = 16'sh1000;
    localparam logic signed [DATA_W-1:0] RST_DEAD_THR   = 16'sh8000;
    localparam logic                     RST_LEARN_EN   = 1'b1;

    typedef struct packed {
        logic pre;
        logic post;
    } t_trace_we;

endpackage

### src/stdp_if.sv
interface stdp_in_if;
    import stdp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [IDX_W-1:0]         pre_index;
    logic [IDX_W-1:0]         post_index;
    logic [DATA_W-1:0]        activity;
    logic signed [DATA_W-1:0] weight_data;

    modport source (output valid, command, pre_index, post_index, activity, weight_data,
                    input ready);
    modport sink (input valid, command, pre_index, post_index, activity, weight_data,
                  output ready);
endinterface

interface stdp_out_if;
    import stdp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         done_command;
    logic signed [DATA_W-1:0] read_weight;

    modport source (output valid, done_command, read_weight, input ready);
    modport sink (input valid, done_command, read_weight, output ready);
endinterface

### src/stdp_trace_weight_update.sv
// Pair-based STDP learning block with online traces and a full weight matrix.
// Items enter on i_cmd (post event, pre event, weight write, weight read) and
// each one gives exactly one acknowledgement item on o_ack, carrying the
// command and, for a read, the stored weight. Configuration registers are
// written through i_cfg_we, i_cfg_index and i_cfg_wdata; the user must write
// them only while the block is idle, which the block itself does not enforce.
// One item is worked on at a time; i_cmd.ready is high only when idle.
// Items with an index out of range, and events while learning is off, are
// ignored but still acknowledged. The time a pre event takes is set by its
// walk over all post neurons: one synapse per cycle through a three-stage
// pipeline built round the shared multiplier pair. The next item can be
// accepted in the same cycle as the acknowledgement of the last one appears.
// After reset a clearing pass zeroes all traces and activities, and no item
// is accepted meanwhile. The weight matrix is not cleared and must be written
// before it is read or updated.
// The acknowledgement sits in an output register; while the receiver stalls,
// the block may accept and finish one more item, then waits in its final state.
`include "assert_macros.svh"

module stdp_trace_weight_update #(
    parameter int NUM_PRE     = stdp_pkg::NUM_PRE_DEF,
    parameter int NUM_POST    = stdp_pkg::NUM_POST_DEF,
    parameter int WEIGHT_BITS = stdp_pkg::WEIGHT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    stdp_in_if.sink                          i_cmd,
    stdp_out_if.source                       o_ack,
    input  logic                             i_cfg_we,
    input  logic [stdp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [stdp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import stdp_pkg::*;

    localparam int PRE_W  = (NUM_PRE > 1) ? $clog2(NUM_PRE) : 1;
    localparam int POST_W = (NUM_POST > 1) ? $clog2(NUM_POST) : 1;
    localparam int DEPTH  = NUM_PRE * NUM_POST;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int K_W    = $clog2(NUM_POST + 1);
    localparam int SUM_W  = ((WEIGHT_BITS > 25) ? WEIGHT_BITS : 25) + 2;

    localparam logic signed [SUM_W-1:0] WMAX_S =
        {{(SUM_W - WEIGHT_BITS + 1){1'b0}}, {(WEIGHT_BITS - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] WMIN_S =
        {{(SUM_W - WEIGHT_BITS + 1){1'b1}}, {(WEIGHT_BITS - 1){1'b0}}};
    localparam logic signed [SUM_W-1:0] S16_MAX_S =
        {{(SUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] S16_MIN_S =
        {{(SUM_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_POST_RD,
        S_POST_MUL,
        S_POST_WR,
        S_PRE_RD,
        S_PRE_MUL,
        S_PRE_SAT,
        S_PRE_GAIN,
        S_PRE_COEF,
        S_WALK,
        S_WR,
        S_RD,
        S_RD_DATA,
        S_DONE
    } t_state;

    function automatic logic [WEIGHT_BITS-1:0] f_sat_w(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        begin
            r = v;
            if (v > WMAX_S) begin
                r = WMAX_S;
            end else if (v < WMIN_S) begin
                r = WMIN_S;
            end
            return r[WEIGHT_BITS-1:0];
        end
    endfunction

    function automatic logic [DATA_W-1:0] f_sat16(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        begin
            r = v;
            if (v > S16_MAX_S) begin
                r = S16_MAX_S;
            end else if (v < S16_MIN_S) begin
                r = S16_MIN_S;
            end
            return r[DATA_W-1:0];
        end
    endfunction

    t_state                   r_state;
    t_state                   n_state;

    logic [DATA_W-1:0]        r_decay_ltp;
    logic [DATA_W-1:0]        r_decay_ltd;
    logic [DATA_W-1:0]        r_gain_ltp;
    logic [DATA_W-1:0]        r_gain_ltd;
    logic signed [DATA_W-1:0] r_weight_min;
    logic signed [DATA_W-1:0] r_weight_max;
    logic signed [DATA_W-1:0] r_dead_thr;
    logic                     r_learn_en;

    logic                     r_out_valid;
    logic [CMD_W-1:0]         r_out_cmd;
    logic signed [DATA_W-1:0] r_out_rd;

    logic [CMD_W-1:0]         r_cmd;
    logic [IDX_W-1:0]         r_pi;
    logic [IDX_W-1:0]         r_qi;
    logic [DATA_W-1:0]        r_act;
    logic signed [DATA_W-1:0] r_wdata;
    logic [AW-1:0]            r_base;
    logic signed [DATA_W-1:0] r_rd;
    logic [DATA_W-1:0]        r_ptr;
    logic [MUL_A_W-1:0]       r_coef_ltp;
    logic [MUL_A_W-1:0]       r_coef_ltd;

    logic [K_W-1:0]           r_k;
    logic                     r_v1;
    logic                     r_v2;
    logic                     r_v3;
    logic [AW-1:0]            r_wa1;
    logic [AW-1:0]            r_wa2;
    logic [AW-1:0]            r_wa3;
    logic signed [WEIGHT_BITS-1:0] r_w2;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_dead;

    logic                     in_acc;
    logic                     pre_ok;
    logic                     post_ok;
    logic                     walk_issue;
    logic                     trace_busy;
    t_trace_we                trace_we;
    logic [PRE_W-1:0]         pre_addr;
    logic [POST_W-1:0]        post_addr;
    logic [DATA_W-1:0]        post_trace_wd;
    logic [DATA_W-1:0]        pre_rdata;
    logic [DATA_W-1:0]        post_trace_rdata;
    logic [DATA_W-1:0]        post_act_rdata;
    logic [16:0]              pre_sum;
    logic [DATA_W-1:0]        ptr;

    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [MUL_A_W-1:0]       mul_c;
    logic [MUL_B_W-1:0]       mul_d;
    logic [PROD_W-1:0]        mul_ab;
    logic [PROD_W-1:0]        mul_cd;

    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [WEIGHT_BITS-1:0]   w_wdata;
    logic [AW-1:0]            w_raddr;
    logic signed [WEIGHT_BITS-1:0] w_rdata;

    logic signed [SUM_W-1:0]  sum_n;
    logic                     dead_n;
    logic signed [SUM_W-1:0]  clamp_v;

    assign in_acc     = i_cmd.valid && i_cmd.ready;
    assign pre_ok     = (32'(i_cmd.pre_index) < NUM_PRE);
    assign post_ok    = (32'(i_cmd.post_index) < NUM_POST);
    assign walk_issue = (r_state == S_WALK) && (r_k < K_W'(NUM_POST));

    assign i_cmd.ready        = (r_state == S_IDLE) && !trace_busy;
    assign o_ack.valid        = r_out_valid;
    assign o_ack.done_command = r_out_cmd;
    assign o_ack.read_weight  = r_out_rd;

    stdp_mul_unit u_mul (
        .i_clk     (i_clk),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .i_c       (mul_c),
        .i_d       (mul_d),
        .o_prod_ab (mul_ab),
        .o_prod_cd (mul_cd)
    );

    stdp_trace_store #(
        .NUM_PRE  (NUM_PRE),
        .NUM_POST (NUM_POST)
    ) u_traces (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_we               (trace_we),
        .i_pre_addr         (pre_addr),
        .i_pre_wdata        (ptr),
        .i_post_addr        (post_addr),
        .i_post_trace_wdata (post_trace_wd),
        .i_post_act_wdata   (r_act),
        .o_pre_rdata        (pre_rdata),
        .o_post_trace_rdata (post_trace_rdata),
        .o_post_act_rdata   (post_act_rdata),
        .o_busy             (trace_busy)
    );

    stdp_weight_store #(
        .DEPTH (DEPTH),
        .WIDTH (WEIGHT_BITS)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Trace paths.
    assign pre_addr      = PRE_W'(r_pi);
    assign post_addr     = (r_state == S_WALK) ? r_k[POST_W-1:0] : POST_W'(r_qi);
    assign post_trace_wd = (r_act != '0) ? r_act : mul_ab[DEC_SHIFT +: DATA_W];
    assign pre_sum       = {1'b0, mul_ab[DEC_SHIFT +: DATA_W]} + {1'b0, r_act};
    assign ptr           = pre_sum[16] ? '1 : pre_sum[DATA_W-1:0];
    assign trace_we.pre  = (r_state == S_PRE_SAT);
    assign trace_we.post = (r_state == S_POST_WR);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mul_c = '0;
        mul_d = '0;
        case (r_state)
            S_POST_MUL: begin
                mul_a = MUL_A_W'(r_decay_ltd);
                mul_b = post_trace_rdata;
            end
            S_PRE_MUL: begin
                mul_a = MUL_A_W'(r_decay_ltp);
                mul_b = pre_rdata;
            end
            S_PRE_GAIN: begin
                mul_a = MUL_A_W'(r_gain_ltp);
                mul_b = r_ptr;
                mul_c = MUL_A_W'(r_gain_ltd);
                mul_d = r_act;
            end
            S_WALK: begin
                mul_a = r_coef_ltp;
                mul_b = post_act_rdata;
                mul_c = r_coef_ltd;
                mul_d = post_trace_rdata;
            end
            default: begin
            end
        endcase
    end

    // Synapse pipeline: read, multiply, sum, then clamp and write back.
    assign sum_n = SUM_W'(r_w2) + SUM_W'(mul_ab[PROD_W-1:PROD_SHIFT])
                 - SUM_W'(mul_cd[PROD_W-1:PROD_SHIFT]);
    assign dead_n = (SUM_W'(r_w2) < SUM_W'(r_dead_thr));

    always_comb begin
        clamp_v = r_sum;
        if (clamp_v < SUM_W'(r_weight_min)) begin
            clamp_v = SUM_W'(r_weight_min);
        end
        if (clamp_v > SUM_W'(r_weight_max)) begin
            clamp_v = SUM_W'(r_weight_max);
        end
    end

    assign w_raddr = (r_state == S_WALK) ? (r_base + AW'(r_k)) : (r_base + AW'(r_qi));

    always_comb begin
        if (r_state == S_WR) begin
            w_we    = 1'b1;
            w_waddr = r_base + AW'(r_qi);
            w_wdata = f_sat_w(SUM_W'(r_wdata));
        end else begin
            w_we    = r_v3 && !r_dead;
            w_waddr = r_wa3;
            w_wdata = f_sat_w(clamp_v);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_cmd.command)
                        CMD_POST: n_state = (r_learn_en && post_ok) ? S_POST_RD : S_DONE;
                        CMD_PRE:  n_state = (r_learn_en && pre_ok) ? S_PRE_RD : S_DONE;
                        CMD_WRITE: n_state = (pre_ok && post_ok) ? S_WR : S_DONE;
                        CMD_READ:  n_state = (pre_ok && post_ok) ? S_RD : S_DONE;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_POST_RD:  n_state = S_POST_MUL;
            S_POST_MUL: n_state = S_POST_WR;
            S_POST_WR:  n_state = S_DONE;
            S_PRE_RD:   n_state = S_PRE_MUL;
            S_PRE_MUL:  n_state = S_PRE_SAT;
            S_PRE_SAT:  n_state = S_PRE_GAIN;
            S_PRE_GAIN: n_state = S_PRE_COEF;
            S_PRE_COEF: n_state = S_WALK;
            S_WALK: begin
                if (!walk_issue && !r_v1 && !r_v2) begin
                    n_state = S_DONE;
                end
            end
            S_WR:      n_state = S_DONE;
            S_RD:      n_state = S_RD_DATA;
            S_RD_DATA: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || o_ack.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_k          <= '0;
            r_decay_ltp  <= RST_DECAY_LTP;
            r_decay_ltd  <= RST_DECAY_LTD;
            r_gain_ltp   <= RST_GAIN_LTP;
            r_gain_ltd   <= RST_GAIN_LTD;
            r_weight_min <= RST_WEIGHT_MIN;
            r_weight_max <= RST_WEIGHT_MAX;
            r_dead_thr   <= RST_DEAD_THR;
            r_learn_en   <= RST_LEARN_EN;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DECAY_LTP:  r_decay_ltp  <= i_cfg_wdata;
                    CFG_DECAY_LTD:  r_decay_ltd  <= i_cfg_wdata;
                    CFG_GAIN_LTP:   r_gain_ltp   <= i_cfg_wdata;
                    CFG_GAIN_LTD:   r_gain_ltd   <= i_cfg_wdata;
                    CFG_WEIGHT_MIN: r_weight_min <= i_cfg_wdata;
                    CFG_WEIGHT_MAX: r_weight_max <= i_cfg_wdata;
                    CFG_DEAD_THR:   r_dead_thr   <= i_cfg_wdata;
                    CFG_LEARN_EN:   r_learn_en   <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (r_state == S_DONE && n_state == S_IDLE) begin
                r_out_valid <= 1'b1;
                r_out_cmd   <= r_cmd;
                r_out_rd    <= r_rd;
            end else if (o_ack.ready) begin
                r_out_valid <= 1'b0;
            end
            r_v1 <= walk_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_state == S_PRE_COEF) begin
                r_k <= '0;
            end else if (walk_issue) begin
                r_k <= r_k + K_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_cmd.command;
            r_pi    <= i_cmd.pre_index;
            r_qi    <= i_cmd.post_index;
            r_act   <= i_cmd.activity;
            r_wdata <= i_cmd.weight_data;
            r_base  <= AW'(32'(i_cmd.pre_index) * 32'(NUM_POST));
            r_rd    <= '0;
        end else if (r_state == S_RD_DATA) begin
            r_rd <= f_sat16(SUM_W'(w_rdata));
        end
        if (r_state == S_PRE_SAT) begin
            r_ptr <= ptr;
        end
        if (r_state == S_PRE_COEF) begin
            r_coef_ltp <= mul_ab[MUL_A_W-1:0];
            r_coef_ltd <= mul_cd[MUL_A_W-1:0];
        end
        r_wa1  <= w_raddr;
        r_wa2  <= r_wa1;
        r_wa3  <= r_wa2;
        r_w2   <= w_rdata;
        r_sum  <= sum_n;
        r_dead <= dead_n;
    end

    `ASSERT_NEXT(a_accept_drops_ready, i_clk, i_rst_n, in_acc, !i_cmd.ready)
    `ASSERT_IMPLIES(a_rd_only_for_read, i_clk, i_rst_n, r_out_valid && r_out_cmd != CMD_READ, r_out_rd == '0)
    `ASSERT_IMPLIES(a_weight_we_state, i_clk, i_rst_n, w_we, r_state == S_WALK || r_state == S_WR)
    `ASSERT_IMPLIES(a_pipe_in_walk, i_clk, i_rst_n, r_v3, r_state == S_WALK)

endmodule

### src/stdp_mul_unit.sv
module stdp_mul_unit (
    input  logic                          i_clk,
    input  logic [stdp_pkg::MUL_A_W-1:0]  i_a,
    input  logic [stdp_pkg::MUL_B_W-1:0]  i_b,
    input  logic [stdp_pkg::MUL_A_W-1:0]  i_c,
    input  logic [stdp_pkg::MUL_B_W-1:0]  i_d,
    output logic [stdp_pkg::PROD_W-1:0]   o_prod_ab,
    output logic [stdp_pkg::PROD_W-1:0]   o_prod_cd
);
    import stdp_pkg::*;

    logic [PROD_W-1:0] r_prod_ab;
    logic [PROD_W-1:0] r_prod_cd;

    always_ff @(posedge i_clk) begin
        r_prod_ab <= PROD_W'(i_a) * PROD_W'(i_b);
        r_prod_cd <= PROD_W'(i_c) * PROD_W'(i_d);
    end

    assign o_prod_ab = r_prod_ab;
    assign o_prod_cd = r_prod_cd;
endmodule

### src/stdp_trace_store.sv
module stdp_trace_store #(
    parameter int  NUM_PRE  = stdp_pkg::NUM_PRE_DEF,
    parameter int  NUM_POST = stdp_pkg::NUM_POST_DEF,
    localparam int PRE_W    = (NUM_PRE > 1) ? $clog2(NUM_PRE) : 1,
    localparam int POST_W   = (NUM_POST > 1) ? $clog2(NUM_POST) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  stdp_pkg::t_trace_we          i_we,
    input  logic [PRE_W-1:0]             i_pre_addr,
    input  logic [stdp_pkg::DATA_W-1:0]  i_pre_wdata,
    input  logic [POST_W-1:0]            i_post_addr,
    input  logic [stdp_pkg::DATA_W-1:0]  i_post_trace_wdata,
    input  logic [stdp_pkg::DATA_W-1:0]  i_post_act_wdata,
    output logic [stdp_pkg::DATA_W-1:0]  o_pre_rdata,
    output logic [stdp_pkg::DATA_W-1:0]  o_post_trace_rdata,
    output logic [stdp_pkg::DATA_W-1:0]  o_post_act_rdata,
    output logic                         o_busy
);
    import stdp_pkg::*;

    localparam int CLR_N = (NUM_PRE > NUM_POST) ? NUM_PRE : NUM_POST;
    localparam int CLR_W = (CLR_N > 1) ? $clog2(CLR_N) : 1;

    logic [DATA_W-1:0] r_pre_mem        [NUM_PRE];
    logic [DATA_W-1:0] r_post_trace_mem [NUM_POST];
    logic [DATA_W-1:0] r_post_act_mem   [NUM_POST];

    logic [DATA_W-1:0] r_pre_rdata;
    logic [DATA_W-1:0] r_post_trace_rdata;
    logic [DATA_W-1:0] r_post_act_rdata;
    logic [CLR_W-1:0]  r_clr_cnt;
    logic              r_busy;

    logic              pre_we;
    logic [PRE_W-1:0]  pre_wa;
    logic [DATA_W-1:0] pre_wd;
    logic              post_we;
    logic [POST_W-1:0] post_wa;
    logic [DATA_W-1:0] post_trace_wd;
    logic [DATA_W-1:0] post_act_wd;

    // After reset every entry is swept to zero, one address per cycle.
    always_comb begin
        if (r_busy) begin
            pre_we        = (32'(r_clr_cnt) < NUM_PRE);
            pre_wa        = r_clr_cnt[PRE_W-1:0];
            pre_wd        = '0;
            post_we       = (32'(r_clr_cnt) < NUM_POST);
            post_wa       = r_clr_cnt[POST_W-1:0];
            post_trace_wd = '0;
            post_act_wd   = '0;
        end else begin
            pre_we        = i_we.pre;
            pre_wa        = i_pre_addr;
            pre_wd        = i_pre_wdata;
            post_we       = i_we.post;
            post_wa       = i_post_addr;
            post_trace_wd = i_post_trace_wdata;
            post_act_wd   = i_post_act_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_busy) begin
            if (r_clr_cnt == CLR_W'(CLR_N - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_clr_cnt <= r_clr_cnt + CLR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pre_we) begin
            r_pre_mem[pre_wa] <= pre_wd;
        end
        r_pre_rdata <= r_pre_mem[i_pre_addr];
    end

    always_ff @(posedge i_clk) begin
        if (post_we) begin
            r_post_trace_mem[post_wa] <= post_trace_wd;
            r_post_act_mem[post_wa]   <= post_act_wd;
        end
        r_post_trace_rdata <= r_post_trace_mem[i_post_addr];
        r_post_act_rdata   <= r_post_act_mem[i_post_addr];
    end

    assign o_pre_rdata        = r_pre_rdata;
    assign o_post_trace_rdata = r_post_trace_rdata;
    assign o_post_act_rdata   = r_post_act_rdata;
    assign o_busy             = r_busy;
endmodule

### src/stdp_weight_store.sv
module stdp_weight_store #(
    parameter int DEPTH = stdp_pkg::NUM_PRE_DEF * stdp_pkg::NUM_POST_DEF,
    parameter int WIDTH = stdp_pkg::WEIGHT_BITS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
